// ===== design/css_pkg.sv =====
`timescale 1ns / 1ps
// css_pkg: shared types and constants of the cocktail shaker sorter
// used by css_front, css_back and cocktail_shaker_sorter_unit; no dependencies

package css_pkg;

    // capacity of the element store (2 to 64)
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // request queue and result queue depth (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // what the back end does with a request
    typedef enum logic [0:0] {
        KIND_STORE = 1'b0,
        KIND_DROP  = 1'b1
    } kind_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_result;
        logic               overflow;
    } out_item_t;

    // classified request as held in the queue
    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
        kind_t              kind;
    } q_item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

endpackage

// ===== design/css_front.sv =====
`timescale 1ns / 1ps
// css_front: accepts requests, classifies them as store or drop, queues them
// depends on css_pkg

module css_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  css_pkg::in_item_t item,
    output css_pkg::q_head_t  head,
    input  logic              pop
);

    css_pkg::q_item_t                q_mem [css_pkg::Q_DEPTH];
    logic [css_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [css_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [css_pkg::Q_CNT_W-1:0]     occ_reg;
    logic [css_pkg::Q_CNT_W-1:0]     occ_next;
    logic [css_pkg::CNT_W-1:0]       set_cnt_reg;
    logic [css_pkg::CNT_W-1:0]       set_cnt_next;
    logic                            push;
    logic                            do_pop;
    css_pkg::q_item_t                new_item;

    // stall only when the queue is full
    assign item_stall = (occ_reg == css_pkg::Q_CNT_W'(css_pkg::Q_DEPTH));
    assign push       = item_valid && !item_stall;
    assign do_pop     = pop && (occ_reg != '0);

    // classify against the number of items already in this set
    always_comb
    begin
        new_item.value      = item.value;
        new_item.final_item = item.final_item;
        new_item.kind       = (set_cnt_reg < css_pkg::CNT_W'(css_pkg::MAX_ITEMS))
                              ? css_pkg::KIND_STORE : css_pkg::KIND_DROP;
    end

    // set counter, back to zero after the marked request
    always_comb
    begin
        set_cnt_next = set_cnt_reg;
        if (push)
        begin
            if (item.final_item)
                set_cnt_next = '0;
            else if (set_cnt_reg < css_pkg::CNT_W'(css_pkg::MAX_ITEMS))
                set_cnt_next = set_cnt_reg + css_pkg::CNT_W'(1);
        end
    end

    // occupancy
    always_comb
    begin
        occ_next = occ_reg;
        if (push && !do_pop)
            occ_next = occ_reg + css_pkg::Q_CNT_W'(1);
        else if (!push && do_pop)
            occ_next = occ_reg - css_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            occ_reg     <= '0;
            set_cnt_reg <= '0;
        end
        else
        begin
            occ_reg     <= occ_next;
            set_cnt_reg <= set_cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + css_pkg::Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + css_pkg::Q_PTR_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_item;
    end

    assign head.valid = (occ_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

endmodule

// ===== design/css_back.sv =====
`timescale 1ns / 1ps
// css_back: element store, shaker sort sequencer and result queue
// depends on css_pkg

module css_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  css_pkg::q_head_t   head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output css_pkg::out_item_t result
);

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_START   = 7'b0000010,
        S_FWD     = 7'b0000100,
        S_FWD_END = 7'b0001000,
        S_BWD     = 7'b0010000,
        S_BWD_END = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [css_pkg::CNT_W-1:0]       count_reg;
    logic [css_pkg::CNT_W-1:0]       count_next;
    logic                            dropped_reg;
    logic                            dropped_next;
    logic [css_pkg::ADDR_W-1:0]      left_reg;
    logic [css_pkg::ADDR_W-1:0]      left_next;
    logic [css_pkg::ADDR_W-1:0]      right_reg;
    logic [css_pkg::ADDR_W-1:0]      right_next;
    logic [css_pkg::ADDR_W-1:0]      rp_reg;
    logic [css_pkg::ADDR_W-1:0]      rp_next;
    logic                            iss_reg;
    logic                            iss_next;
    logic                            rv_reg;
    logic                            rv_next;
    logic [css_pkg::ADDR_W-1:0]      ra_reg;
    logic signed [31:0]              carry_reg;
    logic signed [31:0]              carry_next;

    // element store, one write and one registered read per cycle
    logic signed [31:0]              mem [css_pkg::MAX_ITEMS];
    logic signed [31:0]              rdata_reg;
    logic                            we;
    logic [css_pkg::ADDR_W-1:0]      waddr;
    logic signed [31:0]              wdata;
    logic                            re;

    // result queue
    css_pkg::out_item_t              oq_mem [css_pkg::Q_DEPTH];
    logic [css_pkg::Q_PTR_W-1:0]     oq_wr_reg;
    logic [css_pkg::Q_PTR_W-1:0]     oq_rd_reg;
    logic [css_pkg::Q_CNT_W-1:0]     oq_occ_reg;
    logic                            oq_push;
    logic                            oq_pop;
    css_pkg::out_item_t              oq_item;

    logic [css_pkg::CNT_W-1:0]       cnt_m1;
    logic [css_pkg::ADDR_W-1:0]      last_idx;
    logic [css_pkg::ADDR_W-1:0]      r_dec;
    logic [css_pkg::ADDR_W-1:0]      l_inc;
    logic                            d_lt;
    logic                            room;
    logic                            is_last;

    assign cnt_m1   = count_reg - css_pkg::CNT_W'(1);
    assign last_idx = cnt_m1[css_pkg::ADDR_W-1:0];
    assign r_dec    = right_reg - css_pkg::ADDR_W'(1);
    assign l_inc    = left_reg + css_pkg::ADDR_W'(1);
    assign d_lt     = (rdata_reg < carry_reg);
    assign is_last  = (ra_reg == last_idx);
    assign room     = ((oq_occ_reg + css_pkg::Q_CNT_W'(rv_reg))
                       < css_pkg::Q_CNT_W'(css_pkg::Q_DEPTH));
    assign oq_pop   = (oq_occ_reg != '0) && !result_stall;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        rp_next      = rp_reg;
        iss_next     = iss_reg;
        rv_next      = 1'b0;
        carry_next   = carry_reg;
        we           = 1'b0;
        waddr        = count_reg[css_pkg::ADDR_W-1:0];
        wdata        = head.item.value;
        re           = 1'b0;
        pop          = 1'b0;
        oq_push      = 1'b0;
        oq_item.sorted_value = rdata_reg;
        oq_item.final_result = is_last;
        oq_item.overflow     = dropped_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == css_pkg::KIND_STORE)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + css_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (head.item.final_item)
                        state_next = S_START;
                end
            end

            S_START:
            begin
                left_next  = '0;
                right_next = last_idx;
                rp_next    = '0;
                iss_next   = 1'b1;
                if (count_reg > css_pkg::CNT_W'(1))
                    state_next = S_FWD;
                else
                    state_next = S_OUT;
            end

            // forward pass: carry the largest toward the right bound
            S_FWD:
            begin
                re      = iss_reg;
                rv_next = iss_reg;
                if (iss_reg)
                begin
                    if (rp_reg == right_reg)
                        iss_next = 1'b0;
                    else
                        rp_next = rp_reg + css_pkg::ADDR_W'(1);
                end
                if (rv_reg)
                begin
                    if (ra_reg == left_reg)
                    begin
                        carry_next = rdata_reg;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = ra_reg - css_pkg::ADDR_W'(1);
                        wdata      = d_lt ? rdata_reg : carry_reg;
                        carry_next = d_lt ? carry_reg : rdata_reg;
                    end
                    if (ra_reg == right_reg)
                        state_next = S_FWD_END;
                end
            end

            S_FWD_END:
            begin
                we         = 1'b1;
                waddr      = right_reg;
                wdata      = carry_reg;
                right_next = r_dec;
                if (left_reg < r_dec)
                begin
                    rp_next    = r_dec;
                    iss_next   = 1'b1;
                    state_next = S_BWD;
                end
                else
                begin
                    rp_next    = '0;
                    iss_next   = 1'b1;
                    state_next = S_OUT;
                end
            end

            // backward pass: carry the smallest toward the left bound
            S_BWD:
            begin
                re      = iss_reg;
                rv_next = iss_reg;
                if (iss_reg)
                begin
                    if (rp_reg == left_reg)
                        iss_next = 1'b0;
                    else
                        rp_next = rp_reg - css_pkg::ADDR_W'(1);
                end
                if (rv_reg)
                begin
                    if (ra_reg == right_reg)
                    begin
                        carry_next = rdata_reg;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = ra_reg + css_pkg::ADDR_W'(1);
                        wdata      = d_lt ? carry_reg : rdata_reg;
                        carry_next = d_lt ? rdata_reg : carry_reg;
                    end
                    if (ra_reg == left_reg)
                        state_next = S_BWD_END;
                end
            end

            S_BWD_END:
            begin
                we        = 1'b1;
                waddr     = left_reg;
                wdata     = carry_reg;
                left_next = l_inc;
                if (l_inc < right_reg)
                begin
                    rp_next    = l_inc;
                    iss_next   = 1'b1;
                    state_next = S_FWD;
                end
                else
                begin
                    rp_next    = '0;
                    iss_next   = 1'b1;
                    state_next = S_OUT;
                end
            end

            // stream the sorted store into the result queue
            S_OUT:
            begin
                re      = iss_reg && room;
                rv_next = iss_reg && room;
                if (iss_reg && room)
                begin
                    if (rp_reg == last_idx)
                        iss_next = 1'b0;
                    else
                        rp_next = rp_reg + css_pkg::ADDR_W'(1);
                end
                if (rv_reg)
                begin
                    oq_push = 1'b1;
                    if (is_last)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        left_next    = '0;
                        right_next   = '0;
                        state_next   = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            left_reg    <= '0;
            right_reg   <= '0;
            rp_reg      <= '0;
            iss_reg     <= 1'b0;
            rv_reg      <= 1'b0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_occ_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            rp_reg      <= rp_next;
            iss_reg     <= iss_next;
            rv_reg      <= rv_next;
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + css_pkg::Q_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + css_pkg::Q_PTR_W'(1);
            if (oq_push && !oq_pop)
                oq_occ_reg <= oq_occ_reg + css_pkg::Q_CNT_W'(1);
            else if (!oq_push && oq_pop)
                oq_occ_reg <= oq_occ_reg - css_pkg::Q_CNT_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        ra_reg    <= rp_reg;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[rp_reg];
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= oq_item;
    end

    assign result_valid = (oq_occ_reg != '0);
    assign result       = oq_mem[oq_rd_reg];

    // a pass only runs on a window of at least two elements
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD || state_reg == S_BWD) |-> (left_reg < right_reg))
        else $error("sort pass running on an empty window");

    // returning read data stays inside the window
    a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FWD || state_reg == S_BWD) && rv_reg)
        |-> (ra_reg >= left_reg && ra_reg <= right_reg))
        else $error("read outside the sort window");

    // a store request never finds the element store full
    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && head.valid && head.item.kind == css_pkg::KIND_STORE)
        |-> (count_reg < css_pkg::CNT_W'(css_pkg::MAX_ITEMS)))
        else $error("store request with the element store full");

    // the read credit keeps the result queue from overflowing
    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> (oq_occ_reg < css_pkg::Q_CNT_W'(css_pkg::Q_DEPTH)))
        else $error("push into a full result queue");

endmodule

// ===== design/cocktail_shaker_sorter_unit.sv =====
`timescale 1ns / 1ps
// Usage: a set of signed 32-bit values enters on the item channel, one per
// request, the last one marked with final_item. Up to 64 values are kept;
// further requests of the set are dropped and flag overflow on every result.
// After the marked request the store is sorted ascending in place by
// alternating forward and backward passes, then streamed out on the result
// channel, one value per request, the last marked with final_result.
// Both channels: a request moves at a clock edge with valid high, stall low.
// Loading passes each request through a 4-entry request queue.
// Sorting does one compare-swap per cycle against the element store (one read,
// one write), with a closing write of the carried value at the end of each pass.
// Output then runs at one result per cycle while the result queue has room.
// A stalled receiver holds the result queue; the sorter waits on it without
// losing results, and requests of the next set keep queueing meanwhile.
// Reset (rst_n low, asynchronous) empties both queues and the set; the
// element store is not cleared and needs no clearing pass.
// Depends on css_pkg, css_front and css_back.

module cocktail_shaker_sorter_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  css_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output css_pkg::out_item_t result
);

    css_pkg::q_head_t head;
    logic             pop;

    // request side
    css_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head       (head),
        .pop        (pop)
    );

    // sort and result side
    css_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of cocktail_shaker_sorter_unit
// depends on css_pkg and the sorter design files; feeds sets of values, checks sorted output

module tb_top;

    localparam int RESET_CYCLES = 6;
    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = 50;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    css_pkg::in_item_t  item_req     = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    css_pkg::out_item_t result_item;

    // idle and stall percentages of the current phase
    int send_idle_pct  = 13;
    int recv_stall_pct = 77;

    // requests waiting to be driven
    css_pkg::in_item_t  pending_reqs[$];

    // sorter model: values of the open set, drop flag, sorted results still due
    logic signed [31:0] set_values[$];
    bit                 set_dropped   = 1'b0;
    css_pkg::out_item_t sorted_expect[$];

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  sets_closed     = 0;
    int  results_checked = 0;
    int  overflow_seen   = 0;
    int  idle_cycles     = 0;
    bit  timed_out       = 1'b0;

    cocktail_shaker_sorter_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_item)
    );

    always #4 clk = ~clk;

    // store an accepted request; on the marked one, sort the set and queue its results
    task automatic predict_request(input css_pkg::in_item_t req);
        int                 lo;
        int                 hi;
        int                 k;
        logic signed [31:0] tmp;
        css_pkg::out_item_t res;
        requests_sent++;
        if (set_values.size() < css_pkg::MAX_ITEMS)
            set_values.push_back(req.value);
        else
            set_dropped = 1'b1;
        if (req.final_item)
        begin
            // bidirectional bubble passes over a shrinking window
            lo = 0;
            hi = set_values.size() - 1;
            while (lo < hi)
            begin
                for (k = lo; k < hi; k++)
                begin
                    if (set_values[k] > set_values[k + 1])
                    begin
                        tmp               = set_values[k];
                        set_values[k]     = set_values[k + 1];
                        set_values[k + 1] = tmp;
                    end
                end
                hi--;
                for (k = hi; k > lo; k--)
                begin
                    if (set_values[k - 1] > set_values[k])
                    begin
                        tmp               = set_values[k];
                        set_values[k]     = set_values[k - 1];
                        set_values[k - 1] = tmp;
                    end
                end
                lo++;
            end
            for (k = 0; k < set_values.size(); k++)
            begin
                res.sorted_value = set_values[k];
                res.final_result = (k == set_values.size() - 1);
                res.overflow     = set_dropped;
                sorted_expect.push_back(res);
            end
            set_values.delete();
            set_dropped = 1'b0;
            sets_closed++;
        end
    endtask

    // compare one accepted result with the oldest one due
    task automatic check_result(input css_pkg::out_item_t got);
        css_pkg::out_item_t want;
        if (sorted_expect.size() == 0)
        begin
            $error("result with none due: sorted_value %0d", got.sorted_value);
            error_count++;
        end
        else
        begin
            want = sorted_expect.pop_front();
            results_checked++;
            if (got.overflow)
                overflow_seen++;
            if (got.sorted_value !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                       got.sorted_value);
                error_count++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result: expected %0b, got %0b", want.final_result,
                       got.final_result);
                error_count++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                error_count++;
            end
        end
    endtask

    // request driver: holds a stalled request, otherwise takes the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_req   <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_request(item_req);
            if (!item_valid || !item_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_req   <= pending_reqs.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stall and a watchdog on accepted requests and results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // half full-range values, the rest from a narrow range for duplicates or at the extremes
    function automatic logic signed [31:0] random_value();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: return $urandom_range(0, 8) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_value(input logic signed [31:0] v, input logic last);
        css_pkg::in_item_t req;
        req.value      = v;
        req.final_item = last;
        pending_reqs.push_back(req);
    endtask

    task automatic queue_random_set(input int n);
        int k;
        for (k = 0; k < n; k++)
            queue_value(random_value(), k == n - 1);
    endtask

    // mostly short sets, now and then a medium one
    task automatic queue_random_sets(input int total);
        int added;
        int n;
        added = 0;
        while (added < total)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            queue_random_set(n);
            added += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || item_valid || sorted_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_stimulus();
        int k;
        // single-value sets at both extremes, pairs in both orders
        queue_value(VAL_MIN, 1'b1);
        queue_value(VAL_MAX, 1'b1);
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b1);
        queue_value(VAL_MIN, 1'b0);
        queue_value(VAL_MAX, 1'b1);
        // all equal values
        queue_value(32'sd5, 1'b0);
        queue_value(32'sd5, 1'b0);
        queue_value(32'sd5, 1'b1);
        // descending input
        for (k = 0; k < 6; k++)
            queue_value(3 - k, k == 5);
        // mixed signs and extremes
        queue_value(32'sd0, 1'b0);
        queue_value(-32'sd1, 1'b0);
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b0);
        queue_value(32'sd1, 1'b0);
        queue_value(-32'sd2, 1'b1);
        wait_drained();

        // slow receiver, a set that fills the store exactly
        queue_random_sets(35);
        queue_random_set(css_pkg::MAX_ITEMS);
        wait_drained();

        // slow sender, a set past capacity with the marked request dropped
        send_idle_pct  = 77;
        recv_stall_pct = 13;
        queue_random_sets(35);
        queue_random_set(css_pkg::MAX_ITEMS + 2);
        wait_drained();

        // back to back on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_sets(50);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_stimulus();
            wait (timed_out);
        join_any
        if (sorted_expect.size() != 0)
        begin
            $error("%0d sorted results never arrived", sorted_expect.size());
            error_count++;
        end
        $display("%0d requests in %0d sets sorted, %0d results checked (%0d with overflow)",
                 requests_sent, sets_closed, results_checked, overflow_seen);
        $display("covered extremes, duplicates, a full store and a dropped marked request");
        if (!timed_out && error_count == 0)
            $display("cocktail_shaker_sorter_unit verification clean");
        else
            $display("cocktail_shaker_sorter_unit verification failed");
        $finish;
    end

endmodule
